// ----- hdl/bgms_pkg.sv -----
// Shared constants and types of the glyph metric scanner.
package bgms_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_CELL_SIDE = 8'd0;
  localparam logic [7:0] REG_KEY_COLOR = 8'd1;

  // Register reset values
  localparam logic [5:0]  SIDE_RESET = 6'd16;
  localparam logic [31:0] KEY_RESET  = 32'h00FF_00FF;

  // Cell whose last ink row sets the base row ('A')
  localparam int GLYPH_A = 65;

  // Depth of the cell record queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Fixed widths of the result fields
  localparam int CELL_NUM_W = 8;
  localparam int LEFT_W     = 5;
  localparam int WIDTH_W    = 6;
  localparam int TOP_W      = 6;
  localparam int ADV_W      = 7;
  localparam int ADV_MAX    = 63;
  localparam int ADV_MIN    = -64;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hdl/bitmap_glyph_metric_scanner.sv -----
// Glyph metric scanner: top level with configuration registers and the record queue.
//
// Usage: pixels enter on the in_ channel, one 32-bit pixel per accepted item,
// row-major inside each square cell, cell after cell. Raise in_sheet_start
// with the first pixel of a sheet. The last pixel of each cell yields one
// result on the out_ channel: cell number, left ink column, ink width, the
// sheet-wide top trim and the line advance (base row minus top trim).
// Configuration: cfg_index 0 writes the cell side, 1 the key color; cfg_ready
// is always high. Write only while no cell result is pending.
// Throughput: one pixel per clock while in_stall is low. The front end scans
// a pixel in the cycle it is accepted; a finished cell record goes into a
// four-entry queue, and the back end loads it from the queue into the result
// register when that register is free or being drained.
// When out_stall is high the result holds; the queue absorbs up to four more
// finished cells before in_stall rises.
// Reset (rst_n low, synchronous) restores side 16, key 0xFF00FF, cell 0,
// and empties the queue and the result register.
module bitmap_glyph_metric_scanner
  import bgms_pkg::*;
#(
  parameter int MAX_SIDE  = 32,
  parameter int MAX_CELLS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [31:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            in_pixel_value,
  input  logic                   in_sheet_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CELL_NUM_W-1:0]  out_cell_number,
  output logic [LEFT_W-1:0]      out_left_offset,
  output logic [WIDTH_W-1:0]     out_glyph_width,
  output logic [TOP_W-1:0]       out_top_trim,
  output logic signed [ADV_W-1:0] out_line_advance
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int CNT_W = $clog2(MAX_CELLS);
  localparam int REC_W = MAX_SIDE + 4 * SW + CNT_W + 1;

  logic [5:0]  cell_side_r, cell_side_nxt;
  logic [31:0] key_color_r, key_color_nxt;
  logic [SW-1:0] side;

  logic        accept, cell_done, push, pop;
  q_status_t   q_status;
  logic [REC_W-1:0] push_data, head_data;

  logic [MAX_SIDE-1:0] f_mask, b_mask;
  logic [SW-1:0]       f_first, f_last, f_side, f_start_side;
  logic [SW-1:0]       b_first, b_last, b_side, b_start_side;
  logic [CNT_W-1:0]    f_cell, b_cell;
  logic                f_new_sheet, b_new_sheet;

  assign cfg_ready = 1'b1;

  always_comb begin
    cell_side_nxt = cell_side_r;
    key_color_nxt = key_color_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CELL_SIDE) cell_side_nxt = cfg_wdata[5:0];
      else if (cfg_index == REG_KEY_COLOR) key_color_nxt = cfg_wdata;
    end
    // Clamp side: zero acts as one, oversize as the maximum
    if (cell_side_r == '0) side = SW'(1);
    else if (int'(cell_side_r) > MAX_SIDE) side = SW'(MAX_SIDE);
    else side = SW'(cell_side_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_side_r <= SIDE_RESET;
      key_color_r <= KEY_RESET;
    end else begin
      cell_side_r <= cell_side_nxt;
      key_color_r <= key_color_nxt;
    end
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && cell_done;

  bgms_front #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_CELLS (MAX_CELLS),
    .SW        (SW),
    .CW        (CW),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .pixel_value    (in_pixel_value),
    .sheet_start    (in_sheet_start),
    .key_color      (key_color_r),
    .side           (side),
    .cell_done      (cell_done),
    .rec_mask       (f_mask),
    .rec_first      (f_first),
    .rec_last       (f_last),
    .rec_side       (f_side),
    .rec_cell       (f_cell),
    .rec_new_sheet  (f_new_sheet),
    .rec_start_side (f_start_side)
  );

  assign push_data = {f_mask, f_first, f_last, f_side, f_cell, f_new_sheet, f_start_side};

  bgms_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  assign {b_mask, b_first, b_last, b_side, b_cell, b_new_sheet, b_start_side} = head_data;

  bgms_back #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_CELLS (MAX_CELLS),
    .SW        (SW),
    .CW        (CW),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .rec_mask         (b_mask),
    .rec_first        (b_first),
    .rec_last         (b_last),
    .rec_side         (b_side),
    .rec_cell         (b_cell),
    .rec_new_sheet    (b_new_sheet),
    .rec_start_side   (b_start_side),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_number  (out_cell_number),
    .out_left_offset  (out_left_offset),
    .out_glyph_width  (out_glyph_width),
    .out_top_trim     (out_top_trim),
    .out_line_advance (out_line_advance)
  );

endmodule

// ----- hdl/bgms_front.sv -----
// Front end: classifies each pixel as ink and builds the per-cell record.
module bgms_front
  import bgms_pkg::*;
#(
  parameter int MAX_SIDE  = 32,
  parameter int MAX_CELLS = 256,
  parameter int SW        = $clog2(MAX_SIDE + 1),
  parameter int CW        = $clog2(MAX_SIDE),
  parameter int CNT_W     = $clog2(MAX_CELLS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [31:0]         pixel_value,
  input  logic                sheet_start,
  input  logic [31:0]         key_color,
  input  logic [SW-1:0]       side,
  output logic                cell_done,
  output logic [MAX_SIDE-1:0] rec_mask,
  output logic [SW-1:0]       rec_first,
  output logic [SW-1:0]       rec_last,
  output logic [SW-1:0]       rec_side,
  output logic [CNT_W-1:0]    rec_cell,
  output logic                rec_new_sheet,
  output logic [SW-1:0]       rec_start_side
);

  localparam logic [SW-1:0]    NONE_ROW = SW'(MAX_SIDE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CELLS - 1);

  logic [CW-1:0]       col_r, col_nxt, row_r, row_nxt;
  logic [MAX_SIDE-1:0] mask_r, mask_nxt;
  logic [SW-1:0]       first_r, first_nxt, last_r, last_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                new_sheet_r, new_sheet_nxt;
  logic [SW-1:0]       start_side_r, start_side_nxt;

  logic [CW-1:0]       col, row;
  logic [MAX_SIDE-1:0] mask, mask_upd;
  logic [SW-1:0]       first, last, first_upd, last_upd;
  logic [CNT_W-1:0]    cnt;
  logic                ink, last_col, last_row;

  always_comb begin
    // A sheet start drops the partial cell and begins cell 0
    col   = sheet_start ? '0 : col_r;
    row   = sheet_start ? '0 : row_r;
    mask  = sheet_start ? '0 : mask_r;
    first = sheet_start ? NONE_ROW : first_r;
    last  = sheet_start ? NONE_ROW : last_r;
    cnt   = sheet_start ? '0 : cnt_r;

    ink       = pixel_value != key_color;
    mask_upd  = ink ? (mask | (MAX_SIDE'(1) << col)) : mask;
    first_upd = (ink && first == NONE_ROW) ? SW'(row) : first;
    last_upd  = ink ? SW'(row) : last;

    last_col  = (SW'(col) + SW'(1)) >= side;
    last_row  = (SW'(row) + SW'(1)) >= side;
    cell_done = last_col && last_row;

    rec_mask       = mask_upd;
    rec_first      = first_upd;
    rec_last       = last_upd;
    rec_side       = side;
    rec_cell       = cnt;
    rec_new_sheet  = sheet_start | new_sheet_r;
    rec_start_side = sheet_start ? side : start_side_r;

    col_nxt        = col_r;
    row_nxt        = row_r;
    mask_nxt       = mask_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    new_sheet_nxt  = new_sheet_r;
    start_side_nxt = start_side_r;

    if (accept) begin
      if (cell_done) begin
        col_nxt       = '0;
        row_nxt       = '0;
        mask_nxt      = '0;
        first_nxt     = NONE_ROW;
        last_nxt      = NONE_ROW;
        cnt_nxt       = (cnt == CNT_LAST) ? '0 : cnt + CNT_W'(1);
        new_sheet_nxt = 1'b0;
      end else begin
        col_nxt        = last_col ? '0 : col + CW'(1);
        row_nxt        = last_col ? row + CW'(1) : row;
        mask_nxt       = mask_upd;
        first_nxt      = first_upd;
        last_nxt       = last_upd;
        cnt_nxt        = cnt;
        new_sheet_nxt  = rec_new_sheet;
      end
      start_side_nxt = rec_start_side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      mask_r       <= '0;
      first_r      <= NONE_ROW;
      last_r       <= NONE_ROW;
      cnt_r        <= '0;
      new_sheet_r  <= 1'b0;
      start_side_r <= '0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      mask_r       <= mask_nxt;
      first_r      <= first_nxt;
      last_r       <= last_nxt;
      cnt_r        <= cnt_nxt;
      new_sheet_r  <= new_sheet_nxt;
      start_side_r <= start_side_nxt;
    end
  end

endmodule

// ----- hdl/bgms_queue.sv -----
// Short queue of finished cell records between front and back.
module bgms_queue
  import bgms_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output q_status_t        status
);

  localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  logic [WIDTH-1:0]  entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    head_data    = entry_r[rd_ptr_r];
    status.full  = count_r == FULL_COUNT;
    status.empty = count_r == '0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/bgms_back.sv -----
// Back end: ink extent of a cell, sheet top and base row, result register.
module bgms_back
  import bgms_pkg::*;
#(
  parameter int MAX_SIDE  = 32,
  parameter int MAX_CELLS = 256,
  parameter int SW        = $clog2(MAX_SIDE + 1),
  parameter int CW        = $clog2(MAX_SIDE),
  parameter int CNT_W     = $clog2(MAX_CELLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_status_t             q_status,
  input  logic [MAX_SIDE-1:0]   rec_mask,
  input  logic [SW-1:0]         rec_first,
  input  logic [SW-1:0]         rec_last,
  input  logic [SW-1:0]         rec_side,
  input  logic [CNT_W-1:0]      rec_cell,
  input  logic                  rec_new_sheet,
  input  logic [SW-1:0]         rec_start_side,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CELL_NUM_W-1:0] out_cell_number,
  output logic [LEFT_W-1:0]     out_left_offset,
  output logic [WIDTH_W-1:0]    out_glyph_width,
  output logic [TOP_W-1:0]      out_top_trim,
  output logic signed [ADV_W-1:0] out_line_advance
);

  localparam logic [SW-1:0] NONE_ROW  = SW'(MAX_SIDE);
  localparam int            TOP_INIT  = (int'(SIDE_RESET) > MAX_SIDE) ? MAX_SIDE
                                                                      : int'(SIDE_RESET);
  localparam logic [SW-1:0] TOP_RESET = SW'(TOP_INIT);

  logic [SW-1:0] top_r, top_nxt, base_r, base_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CELL_NUM_W-1:0]   cell_r;
  logic [LEFT_W-1:0]       left_r;
  logic [WIDTH_W-1:0]      width_r;
  logic [TOP_W-1:0]        trim_r;
  logic signed [ADV_W-1:0] adv_r;

  logic [CW-1:0]   lo, hi;
  logic [SW-1:0]   left_calc, width_calc, top0, base0;
  logic [31:0]     cell_ext, left_ext, width_ext, top_ext;
  logic            empty_cell;
  int              adv;

  always_comb begin
    lo = '0;
    hi = '0;
    for (int i = MAX_SIDE - 1; i >= 0; i--) begin
      if (rec_mask[i]) lo = CW'(i);
    end
    for (int i = 0; i < MAX_SIDE; i++) begin
      if (rec_mask[i]) hi = CW'(i);
    end
    empty_cell = rec_mask == '0;
    left_calc  = empty_cell ? '0 : SW'(lo);
    width_calc = empty_cell ? rec_side : SW'(hi) - SW'(lo) + SW'(1);

    // A new sheet restarts top and base at the side seen at its start
    top0  = rec_new_sheet ? rec_start_side : top_r;
    base0 = rec_new_sheet ? rec_start_side : base_r;
    top_nxt  = (rec_first != NONE_ROW && rec_first < top0) ? rec_first : top0;
    base_nxt = (int'(rec_cell) == GLYPH_A && rec_last != NONE_ROW) ? rec_last : base0;

    adv = int'(base_nxt) - int'(top_nxt);
    if (adv > ADV_MAX) adv = ADV_MAX;
    if (adv < ADV_MIN) adv = ADV_MIN;

    cell_ext  = 32'(rec_cell);
    left_ext  = 32'(left_calc);
    width_ext = 32'(width_calc);
    top_ext   = 32'(top_nxt);

    // Take the next record when the result register is free or being drained
    pop           = !q_status.empty && (!out_valid_r || !out_stall);
    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      top_r       <= TOP_RESET;
      base_r      <= TOP_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        top_r  <= top_nxt;
        base_r <= base_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cell_r  <= cell_ext[CELL_NUM_W-1:0];
      left_r  <= left_ext[LEFT_W-1:0];
      width_r <= width_ext[WIDTH_W-1:0];
      trim_r  <= top_ext[TOP_W-1:0];
      adv_r   <= ADV_W'(adv);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_number  = cell_r;
  assign out_left_offset  = left_r;
  assign out_glyph_width  = width_r;
  assign out_top_trim     = trim_r;
  assign out_line_advance = adv_r;

endmodule

// ----- verif/bitmap_glyph_metric_scanner_test.sv -----
// Self-checking testbench for the bitmap glyph metric scanner.
module bitmap_glyph_metric_scanner_test;
  import bgms_pkg::*;

  localparam int SIDE_CAP = 32;
  localparam logic [5:0] NO_INK = 6'd32;
  localparam int RANDOM_ITEMS = 260;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {STEP_PIXEL, STEP_SIDE, STEP_KEY} step_kind_t;

  typedef struct packed {
    logic [7:0]        cell_num;
    logic [4:0]        left;
    logic [5:0]        width;
    logic [5:0]        top;
    logic signed [6:0] adv;
  } glyph_metrics_t;

  typedef struct packed {
    step_kind_t     kind;
    logic [31:0]    data;
    logic           start;
    logic           known;
    glyph_metrics_t want;
  } script_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel_value = '0;
  logic        in_sheet_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [CELL_NUM_W-1:0]   out_cell_number;
  logic [LEFT_W-1:0]       out_left_offset;
  logic [WIDTH_W-1:0]      out_glyph_width;
  logic [TOP_W-1:0]        out_top_trim;
  logic signed [ADV_W-1:0] out_line_advance;

  bitmap_glyph_metric_scanner dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_value(in_pixel_value),
    .in_sheet_start(in_sheet_start),
    .out_valid(out_valid), .out_stall(out_stall), .out_cell_number(out_cell_number),
    .out_left_offset(out_left_offset), .out_glyph_width(out_glyph_width),
    .out_top_trim(out_top_trim), .out_line_advance(out_line_advance)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scanner state as the testbench sees it
  logic [5:0]  side_reg;
  logic [31:0] key_reg;
  logic [31:0] ink_cols;
  logic [4:0]  pix_col, pix_row;
  logic [5:0]  first_row, last_row;
  logic [7:0]  cell_idx;
  logic [5:0]  sheet_top, base_row;

  glyph_metrics_t expected_metrics[$];
  script_step_t   script[$];
  int errors = 0;
  int sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int unsigned stall_left = 0;

  function automatic int unsigned live_side(input logic [5:0] s);
    if (s == 0) return 1;
    if (s > SIDE_CAP) return SIDE_CAP;
    return s;
  endfunction

  function automatic void clear_cell();
    ink_cols = '0;
    pix_col = '0;
    pix_row = '0;
    first_row = NO_INK;
    last_row = NO_INK;
  endfunction

  // Advance the scan by one pixel; returns 1 when the pixel closes a cell
  function automatic bit scan_pixel(input logic [31:0] pix, input logic start,
                                    output glyph_metrics_t m);
    int unsigned s;
    int lo, hi, adv;
    s = live_side(side_reg);
    lo = -1;
    hi = 0;
    m = '0;
    if (start) begin
      clear_cell();
      cell_idx = '0;
      sheet_top = 6'(s);
      base_row = 6'(s);
    end
    if (pix != key_reg) begin
      ink_cols[pix_col] = 1'b1;
      if (first_row == NO_INK) first_row = {1'b0, pix_row};
      last_row = {1'b0, pix_row};
    end
    if (int'(pix_col) + 1 < int'(s)) begin
      pix_col++;
      return 1'b0;
    end
    if (int'(pix_row) + 1 < int'(s)) begin
      pix_col = '0;
      pix_row++;
      return 1'b0;
    end
    for (int i = 0; i < SIDE_CAP; i++) begin
      if (ink_cols[i]) begin
        if (lo < 0) lo = i;
        hi = i;
      end
    end
    if (first_row != NO_INK && first_row < sheet_top) sheet_top = first_row;
    if (cell_idx == GLYPH_A && last_row != NO_INK) base_row = last_row;
    adv = int'(base_row) - int'(sheet_top);
    if (adv > ADV_MAX) adv = ADV_MAX;
    if (adv < ADV_MIN) adv = ADV_MIN;
    m.cell_num = cell_idx;
    m.left = (lo < 0) ? 5'd0 : 5'(lo);
    m.width = (lo < 0) ? 6'(s) : 6'(hi - lo + 1);
    m.top = sheet_top;
    m.adv = 7'(adv);
    cell_idx++;
    clear_cell();
    return 1'b1;
  endfunction

  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_step(input step_kind_t kind, input logic [31:0] data,
                                   input int start, input int known, input int cell_num,
                                   input int left, input int width, input int top,
                                   input int adv);
    script_step_t st;
    st.kind = kind;
    st.data = data;
    st.start = 1'(start);
    st.known = 1'(known);
    st.want = '{8'(cell_num), 5'(left), 6'(width), 6'(top), 7'(adv)};
    script.push_back(st);
  endfunction

  task automatic push_pixel(input logic [31:0] pix, input logic start, input bit typed,
                            input glyph_metrics_t want);
    int unsigned gap;
    glyph_metrics_t m;
    bit closed;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    in_sheet_start <= start;
    do @(posedge clk); while (in_stall);
    closed = scan_pixel(pix, start, m);
    if (typed) expected_metrics.push_back(want);
    else if (closed) expected_metrics.push_back(m);
    sent++;
  endtask

  // Hold the input until every pending cell result has drained
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_metrics.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CELL_SIDE) side_reg = data[5:0];
    else if (idx == REG_KEY_COLOR) key_reg = data;
  endtask

  task automatic run_phase(input logic [5:0] side, input logic [31:0] key, input bit start,
                           input int unsigned npix, input int unsigned density,
                           input logic [31:0] cols);
    logic [31:0] pix, w;
    bit ink, st;
    drain();
    w = $urandom();
    if (w[31]) w[31:6] = '0;
    w[5:0] = side;
    write_reg(REG_CELL_SIDE, w);
    write_reg(REG_KEY_COLOR, key);
    cfg_valid <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < npix; n++) begin
      ink = cols[pix_col] && ($urandom_range(0, 99) < density);
      pix = ink ? $urandom() : key_reg;
      if (ink && pix == key_reg) pix = ~pix;
      st = (n == 0 && start) || ($urandom_range(0, 299) == 0);
      push_pixel(pix, st, 1'b0, '0);
    end
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return key_reg;
    return $urandom();
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_span() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    glyph_metrics_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_metrics.size() == 0) begin
        errors++;
        $display("%0t: result for cell %0d with no item pending", $time, out_cell_number);
      end else begin
        want = expected_metrics.pop_front();
        check_field("cell_number", want.cell_num, out_cell_number);
        check_field("left_offset", want.left, out_left_offset);
        check_field("glyph_width", want.width, out_glyph_width);
        check_field("top_trim", want.top, out_top_trim);
        check_field("line_advance", int'(want.adv), int'(out_line_advance));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int goal;
    int unsigned r, eff, cells, npix, density;
    logic [5:0] side;
    side_reg = SIDE_RESET;
    key_reg = KEY_RESET;
    clear_cell();
    cell_idx = '0;
    sheet_top = SIDE_RESET;
    base_row = SIDE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Side 0 acts as 1: every pixel is a whole cell
    add_step(STEP_SIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 0, 1, 0, 0, 1, 16, 0);
    add_step(STEP_PIXEL, 32'h0000_0000, 0, 1, 1, 0, 1, 0, 16);
    add_step(STEP_PIXEL, KEY_RESET, 1, 1, 0, 0, 1, 1, 0);
    add_step(STEP_PIXEL, 32'hFFFF_FFFF, 0, 1, 1, 0, 1, 0, 1);
    add_step(STEP_PIXEL, 32'h00FF_00FE, 0, 1, 2, 0, 1, 0, 1);
    add_step(STEP_PIXEL, 32'h01FF_00FF, 0, 1, 3, 0, 1, 0, 1);
    add_step(STEP_PIXEL, 32'h0000_0000, 1, 1, 0, 0, 1, 0, 1);
    // 2x2 cells: ink in the right column, then in both columns
    add_step(STEP_SIDE, 2, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 1, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 0, 1, 0, 1, 1, 0, 2);
    add_step(STEP_PIXEL, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, 32'hFFFF_FFFF, 0, 1, 1, 0, 2, 0, 2);
    add_step(STEP_PIXEL, KEY_RESET, 0, 0, 0, 0, 0, 0, 0);
    // Grow the side past the cap mid-cell, then shrink it to end the cell early
    add_step(STEP_SIDE, 63, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_SIDE, 1, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, KEY_RESET, 0, 1, 2, 1, 1, 0, 2);
    // Swap the key: zero becomes background, magenta becomes ink
    add_step(STEP_KEY, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(STEP_PIXEL, 32'h0000_0000, 0, 1, 3, 0, 1, 0, 2);
    add_step(STEP_PIXEL, KEY_RESET, 0, 1, 4, 0, 1, 0, 2);

    foreach (script[i]) begin
      if (script[i].kind == STEP_PIXEL) begin
        push_pixel(script[i].data, script[i].start, script[i].known, script[i].want);
      end else begin
        drain();
        write_reg(script[i].kind == STEP_SIDE ? REG_CELL_SIDE : REG_KEY_COLOR,
                  script[i].data);
        cfg_valid <= 1'b0;
      end
    end

    // Wrap the cell counter, then land cell 65 on a taller cell
    run_phase(6'd0, 32'hFFFF_FFFF, 1'b1, 300, 50, '1);
    run_phase(6'd1, $urandom(), 1'b1, 65, 50, '1);
    run_phase(6'd6, key_reg, 1'b0, 3 * 36, 40, '1);
    // Full-size rows cut short by a side change: top at the cap, far-right ink, full width
    run_phase(6'd32, key_reg, 1'b1, 32, 0, '1);
    run_phase(6'd1, key_reg, 1'b0, 1, 0, '1);
    run_phase(6'd32, key_reg, 1'b1, 32, 100, 32'h8000_0000);
    run_phase(6'd1, key_reg, 1'b0, 1, 0, '1);
    run_phase(6'd32, key_reg, 1'b0, 32, 100, 32'h8000_0001);
    run_phase(6'd1, key_reg, 1'b0, 1, 0, '1);

    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      r = $urandom_range(0, 31);
      if (r < 2) side = (r == 0) ? 6'd0 : 6'($urandom_range(33, 63));
      else if (r < 14) side = 6'($urandom_range(1, 2));
      else if (r < 24) side = 6'($urandom_range(3, 6));
      else if (r < 29) side = 6'($urandom_range(7, 12));
      else if (r < 31) side = 6'($urandom_range(13, 24));
      else side = 6'($urandom_range(25, 32));
      eff = live_side(side);
      if (eff <= 2) cells = $urandom_range(1, 60);
      else if (eff <= 6) cells = $urandom_range(1, 8);
      else if (eff <= 12) cells = $urandom_range(1, 3);
      else cells = 1;
      npix = cells * eff * eff;
      // Stop large cells early and some others mid-cell
      if (eff > 12 || $urandom_range(0, 3) == 0) npix = $urandom_range(1, npix);
      case ($urandom_range(0, 5))
        0: density = 0;
        1: density = 100;
        2: density = 5;
        default: density = $urandom_range(0, 100);
      endcase
      run_phase(side, pick_key(), $urandom_range(0, 2) == 0, npix, density,
                $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom());
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bgms_pkg.sv
hdl/bgms_front.sv
hdl/bgms_queue.sv
hdl/bgms_back.sv
hdl/bitmap_glyph_metric_scanner.sv
verif/bitmap_glyph_metric_scanner_test.sv
